// ===== src/pivt_pkg.sv =====
// Types and codes shared by the point-in-volume table.
package pivt_pkg;

  typedef enum logic [2:0] {
    OP_ADD_SPHERE = 3'd0,
    OP_ADD_BOX    = 3'd1,
    OP_ADD_CYL    = 3'd2,
    OP_ADD_TRI    = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_SET_EN     = 3'd5,
    OP_READ_EN    = 3'd6,
    OP_QUERY      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KIND_SPHERE = 2'd0,
    KIND_BOX    = 2'd1,
    KIND_CYL    = 2'd2,
    KIND_TRI    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_MUL,
    S_ADD_WR,
    S_RD,
    S_EVAL,
    S_MUL,
    S_DONE
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [15:0]       tag;
    logic              active;
    logic [7:0][31:0]  coords;
    logic [63:0]       rsq;
  } entry_t;

endpackage

// ===== src/point_in_volume_table.sv =====
// Per op: add squares the radius, then writes; remove and set enable check every stored entry;
// read enable and query scan until a match or hit, a query multiplying only for an enabled
// sphere, or a cylinder or triangle in its height range; other ops on an empty table post at once.
// Throughput: one transaction at a time, the next accepted the cycle after the result is
// posted; the shared 32x32 multiplier and the one-read, one-write entry memory with registered
// read set the per-entry cost. A result held by a stalled receiver delays the posting.
// Reset clears the entry count and handshake state; entry storage is left unwritten and
// only entries below the count are ever read.
module point_in_volume_table
  import pivt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: barrier_id[15:0], enable_flag[16], geom_0..geom_7 32 bits each from bit 17, pad
  input  logic [279:0] s_axis_tdata_i,
  // tuser: operation[2:0]
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: hit_id[15:0], enable_state[16], entry_count[22:17], pad
  output logic [23:0]  m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]   m_axis_tuser_o
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // entry memory
  entry_t          mem_q [TABLE_DEPTH];
  entry_t          ent_q;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [15:0]     id_q, id_d;
  logic            en_q, en_d;
  logic [7:0][31:0] g_q, g_d;
  logic [CW-1:0]   cnt_q, cnt_d, rem_q, rem_d, j_q, j_d;
  logic [IW-1:0]   a_q, a_d;
  logic            found_q, found_d, fail_q, fail_d, pneg_q, pneg_d;
  status_e         status_q, status_d;
  logic [15:0]     hit_q, hit_d;
  logic            est_q, est_d;
  logic [2:0]      s_q, s_d;
  logic signed [66:0] acc_q, acc_d;
  logic [63:0]     prod_q;
  logic [31:0]     mul_a, mul_b;
  logic            mul_en;
  logic            mv_q, mv_d;
  logic [23:0]     mdata_q, mdata_d;
  status_e         mstat_q, mstat_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    ent_q <= mem_q[a_q];
  end

  function automatic logic signed [32:0] sub33(logic [31:0] x, logic [31:0] y);
    return $signed({x[31], x}) - $signed({y[31], y});
  endfunction

  function automatic logic [32:0] mag33(logic signed [32:0] d);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
  end

  // operand selection for the current multiply step
  logic signed [32:0] da, db;
  logic [32:0]        ma, mb;
  logic [2:0]         nterms;
  logic [31:0]        px, py, pz;
  logic [7:0][31:0]   c;
  logic signed [66:0] acc_add, prod_s;
  logic               in_h, in_box;
  logic signed [32:0] top;
  logic [CW+5:0]      cnt_ext;
  entry_t             new_ent;
  logic [31:0]        r_mag;

  always_comb begin
    px = g_q[0];
    py = g_q[1];
    pz = g_q[2];
    c  = ent_q.coords;
    da = '0;
    db = '0;
    unique case (ent_q.kind)
      KIND_SPHERE: begin
        nterms = 3'd3;
        if (s_q == 3'd0)      da = sub33(c[0], px);
        else if (s_q == 3'd1) da = sub33(c[1], py);
        else                  da = sub33(c[2], pz);
        db = da;
      end
      KIND_CYL: begin
        nterms = 3'd2;
        da = (s_q == 3'd0) ? sub33(c[0], px) : sub33(c[2], pz);
        db = da;
      end
      KIND_TRI: begin
        nterms = 3'd6;
        unique case (s_q)
          3'd0: begin da = sub33(px, c[0]); db = sub33(c[4], c[2]); end
          3'd1: begin da = sub33(pz, c[2]); db = sub33(c[0], c[3]); end
          3'd2: begin da = sub33(px, c[3]); db = sub33(c[6], c[4]); end
          3'd3: begin da = sub33(pz, c[4]); db = sub33(c[3], c[5]); end
          3'd4: begin da = sub33(px, c[5]); db = sub33(c[2], c[6]); end
          3'd5: begin da = sub33(pz, c[6]); db = sub33(c[5], c[0]); end
          default: begin da = '0; db = '0; end
        endcase
      end
      default: nterms = 3'd0;
    endcase
    ma = mag33(da);
    mb = mag33(db);
    prod_s  = $signed({3'b000, prod_q});
    acc_add = acc_q + (pneg_q ? -prod_s : prod_s);
    top  = $signed({c[1][31], c[1]}) + $signed({c[7][31], c[7]});
    in_h = ($signed(py) >= $signed(c[1])) && ($signed({py[31], py}) <= top);
    in_box = ($signed(px) >= $signed(c[0])) && ($signed(px) <= $signed(c[3])) &&
             ($signed(py) >= $signed(c[1])) && ($signed(py) <= $signed(c[4])) &&
             ($signed(pz) >= $signed(c[2])) && ($signed(pz) <= $signed(c[5]));
    r_mag = 32'(mag33($signed({g_q[3][31], g_q[3]})));
    cnt_ext = {6'd0, cnt_q};
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    id_d     = id_q;
    en_d     = en_q;
    g_d      = g_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    j_d      = j_q;
    a_d      = a_q;
    found_d  = found_q;
    fail_d   = fail_q;
    pneg_d   = pneg_q;
    status_d = status_q;
    hit_d    = hit_q;
    est_d    = est_q;
    s_d      = s_q;
    acc_d    = acc_q;
    mv_d     = mv_q;
    mdata_d  = mdata_q;
    mstat_d  = mstat_q;
    mem_we   = 1'b0;
    mem_waddr = j_q[IW-1:0];
    mem_wdata = ent_q;
    mul_en   = 1'b0;
    mul_a    = ma[31:0];
    mul_b    = mb[31:0];
    s_axis_tready_o = (state_q == S_IDLE);

    new_ent.kind   = kind_e'(op_q[1:0]);
    new_ent.tag    = id_q;
    new_ent.active = en_q;
    new_ent.rsq    = prod_q;
    new_ent.coords = '0;
    unique case (op_q)
      OP_ADD_BOX: begin
        for (int k = 0; k < 3; k++) begin
          if ($signed(g_q[k]) < $signed(g_q[k+3])) begin
            new_ent.coords[k]   = g_q[k];
            new_ent.coords[k+3] = g_q[k+3];
          end else begin
            new_ent.coords[k]   = g_q[k+3];
            new_ent.coords[k+3] = g_q[k];
          end
        end
      end
      OP_ADD_TRI: new_ent.coords = g_q;
      default: begin
        new_ent.coords[0] = g_q[0];
        new_ent.coords[1] = g_q[1];
        new_ent.coords[2] = g_q[2];
        new_ent.coords[7] = g_q[7];
      end
    endcase

    if (mv_q && m_axis_tready_i) mv_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d     = op_e'(s_axis_tuser_i);
          id_d     = s_axis_tdata_i[15:0];
          en_d     = s_axis_tdata_i[16];
          for (int k = 0; k < 8; k++) g_d[k] = s_axis_tdata_i[17 + 32*k +: 32];
          status_d = ST_OK;
          hit_d    = '0;
          est_d    = 1'b0;
          found_d  = 1'b0;
          j_d      = '0;
          rem_d    = cnt_q;
          unique case (op_e'(s_axis_tuser_i))
            OP_ADD_SPHERE, OP_ADD_BOX, OP_ADD_CYL, OP_ADD_TRI: begin
              if (cnt_q == CW'(TABLE_DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                state_d = S_ADD_MUL;
              end
            end
            OP_REMOVE, OP_SET_EN: begin
              a_d = '0;
              if (cnt_q == '0) begin
                status_d = ST_NOT_FOUND;
                state_d  = S_DONE;
              end else begin
                state_d = S_RD;
              end
            end
            OP_READ_EN, OP_QUERY: begin
              a_d = IW'(cnt_q - 1'b1);
              if (cnt_q == '0) begin
                if (op_e'(s_axis_tuser_i) == OP_READ_EN) status_d = ST_NOT_FOUND;
                state_d = S_DONE;
              end else begin
                state_d = S_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_ADD_MUL: begin
        mul_en  = 1'b1;
        mul_a   = r_mag;
        mul_b   = r_mag;
        state_d = S_ADD_WR;
      end
      S_ADD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IW-1:0];
        mem_wdata = new_ent;
        cnt_d     = cnt_q + 1'b1;
        state_d   = S_DONE;
      end
      S_RD: state_d = S_EVAL;
      S_EVAL: begin
        logic advance;
        advance = 1'b1;
        unique case (op_q)
          OP_REMOVE: begin
            if (ent_q.tag == id_q) begin
              found_d = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = j_q[IW-1:0];
              j_d       = j_q + 1'b1;
            end
            if (rem_q == CW'(1)) cnt_d = j_d;
          end
          OP_SET_EN: begin
            if (ent_q.tag == id_q) begin
              found_d          = 1'b1;
              mem_we           = 1'b1;
              mem_waddr        = a_q;
              mem_wdata.active = en_q;
            end
          end
          OP_READ_EN: begin
            if (ent_q.tag == id_q) begin
              est_d   = ent_q.active;
              advance = 1'b0;
              state_d = S_DONE;
            end else if (rem_q == CW'(1)) begin
              status_d = ST_NOT_FOUND;
            end
          end
          OP_QUERY: begin
            if (ent_q.active) begin
              if (ent_q.kind == KIND_BOX) begin
                if (in_box) begin
                  hit_d   = ent_q.tag;
                  advance = 1'b0;
                  state_d = S_DONE;
                end
              end else if (ent_q.kind == KIND_SPHERE || in_h) begin
                advance = 1'b0;
                s_d     = '0;
                acc_d   = '0;
                fail_d  = 1'b0;
                state_d = S_MUL;
              end
            end
          end
          default: ;
        endcase
        if (advance) begin
          if (rem_q == CW'(1)) begin
            if ((op_q == OP_REMOVE || op_q == OP_SET_EN) && !found_d)
              status_d = ST_NOT_FOUND;
            state_d = S_DONE;
          end else begin
            rem_d   = rem_q - 1'b1;
            a_d     = (op_q == OP_REMOVE || op_q == OP_SET_EN) ? a_q + 1'b1 : a_q - 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_MUL: begin
        logic edge_neg, hit;
        edge_neg = 1'b0;
        hit      = 1'b0;
        if (s_q != 3'd0) acc_d = acc_add;
        if (ent_q.kind == KIND_TRI && s_q != 3'd0 && !s_q[0]) begin
          edge_neg = acc_add < 0;
          if (edge_neg) fail_d = 1'b1;
          acc_d = '0;
        end
        if (s_q < nterms) begin
          mul_en = 1'b1;
          pneg_d = (ent_q.kind == KIND_TRI) && (da[32] ^ db[32]);
          if (ent_q.kind != KIND_TRI && ma > 33'h080000000) fail_d = 1'b1;
          s_d = s_q + 1'b1;
        end else begin
          if (ent_q.kind == KIND_TRI) hit = !(fail_q || edge_neg);
          else hit = !fail_q && (acc_add <= $signed({3'b000, ent_q.rsq}));
          if (hit) begin
            hit_d   = ent_q.tag;
            state_d = S_DONE;
          end else if (rem_q == CW'(1)) begin
            state_d = S_DONE;
          end else begin
            rem_d   = rem_q - 1'b1;
            a_d     = a_q - 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_DONE: begin
        if (!mv_q || m_axis_tready_i) begin
          mv_d    = 1'b1;
          mdata_d = {1'b0, cnt_ext[5:0], est_q, hit_q};
          mstat_d = status_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    id_q     <= id_d;
    en_q     <= en_d;
    g_q      <= g_d;
    rem_q    <= rem_d;
    j_q      <= j_d;
    a_q      <= a_d;
    found_q  <= found_d;
    fail_q   <= fail_d;
    pneg_q   <= pneg_d;
    status_q <= status_d;
    hit_q    <= hit_d;
    est_q    <= est_d;
    s_q      <= s_d;
    acc_q    <= acc_d;
    mdata_q  <= mdata_d;
    mstat_q  <= mstat_d;
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = mstat_q;

endmodule
